@@ rtl/core/cjt_pkg.sv @@
// ----------------------------------------------------------------------------
// cjt_pkg
// Shared types and constants for the centroid jitter tracker.
// ----------------------------------------------------------------------------
package cjt_pkg;

  localparam int unsigned WINDOW_DEF = 8;    // default history depth

  localparam int unsigned PIX_W  = 11;       // box fields, whole pixels
  localparam int unsigned BLUE_W = 15;       // blue centre, 1/16 pixel
  localparam int unsigned CEN_W  = 16;       // stored centre, 1/16 pixel
  localparam int unsigned DEV_W  = 16;       // per-track deviation
  localparam int unsigned REL_W  = 17;       // green minus blue deviation

  localparam int unsigned DEV_LIM = 32767;   // deviation saturation bound

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LATCH,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } cjt_state_e;

  // axis order: at most one divide per axis, none on the first frame
  typedef enum logic [1:0] {
    AX_GX,
    AX_GY,
    AX_BX,
    AX_BY
  } cjt_axis_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cjt_div_stat_t;

endpackage

@@ rtl/core/cjt_ram.sv @@
// ----------------------------------------------------------------------------
// cjt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cjt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/cjt_div.sv @@
// ----------------------------------------------------------------------------
// cjt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cjt_div #(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned DEN_W = 5,
  parameter int unsigned QUO_W = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]       den_i,
  output cjt_pkg::cjt_div_stat_t stat_o,
  output logic [QUO_W-1:0]       quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] acc_q;   // dividend in, quotient out

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = acc_q[QUO_W-1:0];

endmodule

@@ rtl/core/centroid_jitter_tracker.sv @@
// ----------------------------------------------------------------------------
// centroid_jitter_tracker
// Per-frame centre jitter of a green box track and a blue point track.
// ----------------------------------------------------------------------------
// Sequence: for each of the four axes in turn, read the ring slot about to be
//   replaced, divide for the rounded mean (skipped on the first frame), then
//   update; the bit-serial divider is shared across the four axes. A new item
//   is taken only in idle, after the previous result goes to the output.
// Reset: async active low; clears history count, ring pointer, running sums
//   and output valid. Ring RAM contents are never cleared.
// ----------------------------------------------------------------------------
module centroid_jitter_tracker #(
  parameter int unsigned WINDOW = cjt_pkg::WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cjt_pkg::PIX_W-1:0]           green_left_i,
  input  logic [cjt_pkg::PIX_W-1:0]           green_top_i,
  input  logic [cjt_pkg::PIX_W-1:0]           green_width_i,
  input  logic [cjt_pkg::PIX_W-1:0]           green_height_i,
  input  logic                                blue_valid_i,
  input  logic [cjt_pkg::BLUE_W-1:0]          blue_cx_i,
  input  logic [cjt_pkg::BLUE_W-1:0]          blue_cy_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cjt_pkg::DEV_W-1:0]    green_dev_x_o,
  output logic signed [cjt_pkg::DEV_W-1:0]    green_dev_y_o,
  output logic signed [cjt_pkg::DEV_W-1:0]    blue_dev_x_o,
  output logic signed [cjt_pkg::DEV_W-1:0]    blue_dev_y_o,
  output logic signed [cjt_pkg::REL_W-1:0]    rel_dev_x_o,
  output logic signed [cjt_pkg::REL_W-1:0]    rel_dev_y_o
);

  localparam int unsigned CEN_W  = cjt_pkg::CEN_W;
  localparam int unsigned DEV_W  = cjt_pkg::DEV_W;
  localparam int unsigned REL_W  = cjt_pkg::REL_W;
  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = CEN_W + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + 1;     // 2*sum + count
  localparam int unsigned DEN_W  = CNT_W + 1;     // 2*count
  localparam int unsigned ADDR_W = IDX_W + 2;     // {axis, ring index}
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  localparam logic signed [DEV_W:0] SAT_HI = (DEV_W+1)'(cjt_pkg::DEV_LIM);
  localparam logic signed [DEV_W:0] SAT_LO = -SAT_HI;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  cjt_pkg::cjt_state_e state_q, state_d;
  cjt_pkg::cjt_axis_e  axis_q;

  logic [CNT_W-1:0]    frames_q;      // earlier frames held, 0..WINDOW
  logic [IDX_W-1:0]    ptr_q;         // next ring slot to overwrite
  logic [SUM_W-1:0]    sum_q [4];     // running sum of held centres per axis
  logic [CEN_W-1:0]    cur_q [4];     // this frame's centres
  logic signed [DEV_W-1:0] dev_q [4]; // deviations as they come out
  logic                out_valid_q;

  // --------------------------------------------------------------------------
  // Shared divider and ring RAM
  // --------------------------------------------------------------------------
  logic                   div_start;
  cjt_pkg::cjt_div_stat_t div_stat;
  logic [CEN_W-1:0]       div_quo;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_addr;
  logic [CEN_W-1:0]       ram_rdata;

  logic                   in_acc, out_free, held_any, full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign held_any = frames_q != '0;
  assign full     = frames_q == CNT_W'(WINDOW);
  assign ram_addr = {axis_q, ptr_q};

  // rounded mean = (2*sum + n) / (2*n), ties go up
  assign div_num = {sum_q[axis_q], 1'b0} + NUM_W'(frames_q);
  assign div_den = {frames_q, 1'b0};

  cjt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (CEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // four rings packed in one RAM, axis in the top address bits
  cjt_ram #(
    .WIDTH (CEN_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (cur_q[axis_q]),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Deviation and running-sum update for the current axis
  // --------------------------------------------------------------------------
  logic signed [DEV_W:0]   diff;
  logic signed [DEV_W-1:0] dev_new;
  logic [SUM_W-1:0]        sum_new;

  assign diff = $signed({1'b0, cur_q[axis_q]}) - $signed({1'b0, div_quo});

  always_comb begin
    if (!held_any) begin
      dev_new = '0;
    end else if (diff > SAT_HI) begin
      dev_new = SAT_HI[DEV_W-1:0];
    end else if (diff < SAT_LO) begin
      dev_new = SAT_LO[DEV_W-1:0];
    end else begin
      dev_new = diff[DEV_W-1:0];
    end
  end

  // once full, the slot being overwritten drops out of the window
  assign sum_new = sum_q[axis_q] + SUM_W'(cur_q[axis_q])
                 - (full ? SUM_W'(ram_rdata) : SUM_W'(0));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cjt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      cjt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = cjt_pkg::ST_READ;
        end
      end
      cjt_pkg::ST_READ: begin
        ram_re  = 1'b1;       // fetch slot about to be replaced
        state_d = cjt_pkg::ST_LATCH;
      end
      cjt_pkg::ST_LATCH: begin
        if (held_any) begin
          div_start = 1'b1;
          state_d   = cjt_pkg::ST_DIV;
        end else begin
          state_d = cjt_pkg::ST_UPD;
        end
      end
      cjt_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = cjt_pkg::ST_UPD;
        end
      end
      cjt_pkg::ST_UPD: begin
        ram_we = 1'b1;
        if (axis_q == cjt_pkg::AX_BY) begin
          state_d = cjt_pkg::ST_FIN;
        end else begin
          state_d = cjt_pkg::ST_READ;
        end
      end
      cjt_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = cjt_pkg::ST_IDLE;
        end
      end
      default: state_d = cjt_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q      <= cjt_pkg::AX_GX;
      frames_q    <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        axis_q <= cjt_pkg::AX_GX;
      end
      if (state_q == cjt_pkg::ST_UPD) begin
        sum_q[axis_q] <= sum_new;
        axis_q        <= cjt_pkg::cjt_axis_e'(2'(axis_q + 2'd1));
      end
      if (state_q == cjt_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        ptr_q       <= (ptr_q == IDX_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        if (!full) begin
          frames_q <= frames_q + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q[cjt_pkg::AX_GX] <= CEN_W'({green_left_i, 4'b0}) + CEN_W'({green_width_i, 3'b0});
      cur_q[cjt_pkg::AX_GY] <= CEN_W'({green_top_i, 4'b0}) + CEN_W'({green_height_i, 3'b0});
      cur_q[cjt_pkg::AX_BX] <= blue_valid_i ? CEN_W'(blue_cx_i) : '0;
      cur_q[cjt_pkg::AX_BY] <= blue_valid_i ? CEN_W'(blue_cy_i) : '0;
    end
    if (state_q == cjt_pkg::ST_UPD) begin
      dev_q[axis_q] <= dev_new;
    end
    if (state_q == cjt_pkg::ST_FIN && out_free) begin
      green_dev_x_o <= dev_q[cjt_pkg::AX_GX];
      green_dev_y_o <= dev_q[cjt_pkg::AX_GY];
      blue_dev_x_o  <= dev_q[cjt_pkg::AX_BX];
      blue_dev_y_o  <= dev_q[cjt_pkg::AX_BY];
      rel_dev_x_o   <= REL_W'(dev_q[cjt_pkg::AX_GX]) - REL_W'(dev_q[cjt_pkg::AX_BX]);
      rel_dev_y_o   <= REL_W'(dev_q[cjt_pkg::AX_GY]) - REL_W'(dev_q[cjt_pkg::AX_BY]);
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_frames_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= CNT_W'(WINDOW))
    else $error("history count beyond window");

  // in the first frame the sums build up before the count moves, so check them between items
  a_empty_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cjt_pkg::ST_IDLE && frames_q == '0) |->
      (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0 && sum_q[3] == '0))
    else $error("running sum nonzero with empty history");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == cjt_pkg::ST_READ && axis_q == cjt_pkg::AX_GX))
    else $error("item accepted without starting at first axis");

  a_rel_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rel_dev_x_o == REL_W'(green_dev_x_o) - REL_W'(blue_dev_x_o) &&
                     rel_dev_y_o == REL_W'(green_dev_y_o) - REL_W'(blue_dev_y_o)))
    else $error("relative deviation does not match track deviations");

endmodule
